// ===== hw/rtl/cste_pkg.sv =====
// Shared types, command codes and the default signal table of the CAN signal table extractor.
package cste_pkg;

    localparam int IdxMaxW      = 6;
    localparam int DfltCount    = 16;
    localparam int DfltEnabled  = 13;
    localparam int MaskW        = 16;
    localparam int MaxLen       = 32;

    typedef enum logic [1:0] {
        CMD_FRAME = 2'd0,
        CMD_SET   = 2'd1,
        CMD_READ  = 2'd2
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SCAN,
        ST_SET,
        ST_READ,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic [10:0] id;
        logic [5:0]  start_bit;
        logic [5:0]  length;
        logic        enabled;
        logic [31:0] value;
    } t_entry;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic scan_rd;
        logic scan_upd;
        logic set_wr;
        logic entry_rd;
        logic out_load;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic [1:0] cmd;
        logic       idx_ok;
    } t_dp_status;

    localparam logic [10:0] DfltId [DfltCount] = '{
        11'h360, 11'h360, 11'h361, 11'h3E0, 11'h390, 11'h390, 11'h390, 11'h390,
        11'h390, 11'h390, 11'h373, 11'h368, 11'h3EB, 11'h000, 11'h000, 11'h000
    };
    localparam logic [5:0] DfltStart [DfltCount] = '{
        6'd0, 6'd32, 6'd16, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0,
        6'd0, 6'd0, 6'd0, 6'd0, 6'd32, 6'd0, 6'd0, 6'd0
    };
    localparam logic [5:0] DfltLen [DfltCount] = '{
        6'd16, 6'd16, 6'd16, 6'd16, 6'd16, 6'd16, 6'd16, 6'd16,
        6'd16, 6'd16, 6'd16, 6'd16, 6'd16, 6'd0, 6'd0, 6'd0
    };

    // Entry contents right after reset
    function automatic t_entry default_entry(logic [IdxMaxW-1:0] idx);
        t_entry e;
        e = '0;
        e.value = '1;
        if (idx < IdxMaxW'(DfltCount)) begin
            e.id        = DfltId[idx[3:0]];
            e.start_bit = DfltStart[idx[3:0]];
            e.length    = DfltLen[idx[3:0]];
        end
        e.enabled = (idx < IdxMaxW'(DfltEnabled));
        return e;
    endfunction

endpackage

// ===== hw/rtl/cste_ctrl.sv =====
// Controller state machine: sequences decode, table scan, entry write/read and result hand-off.
module cste_ctrl #(
    parameter int NUM_ENTRIES = 16,
    parameter int AW          = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    input  cste_pkg::t_dp_status  i_status,
    output cste_pkg::t_dp_cmd     o_cmd,
    output logic [AW-1:0]         o_scan_addr
);

    localparam int CW = $clog2(NUM_ENTRIES + 1);

    cste_pkg::t_state r_state, n_state;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             r_out_vld, n_out_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= cste_pkg::ST_IDLE;
            r_cnt     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_out_vld <= n_out_vld;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_scan_addr = r_cnt[AW-1:0];
        case (r_state)
            cste_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = cste_pkg::ST_DECODE;
                end
            end
            cste_pkg::ST_DECODE: begin
                n_cnt = '0;
                case (i_status.cmd)
                    cste_pkg::CMD_FRAME: n_state = cste_pkg::ST_SCAN;
                    cste_pkg::CMD_SET:
                        n_state = i_status.idx_ok ? cste_pkg::ST_SET : cste_pkg::ST_OUT;
                    cste_pkg::CMD_READ:
                        n_state = i_status.idx_ok ? cste_pkg::ST_READ : cste_pkg::ST_OUT;
                    default: n_state = cste_pkg::ST_OUT;
                endcase
            end
            cste_pkg::ST_SCAN: begin
                // read entry cnt while the entry read last cycle is checked and updated
                o_cmd.scan_rd  = (r_cnt != CW'(NUM_ENTRIES));
                o_cmd.scan_upd = (r_cnt != '0);
                if (r_cnt == CW'(NUM_ENTRIES)) begin
                    n_state = cste_pkg::ST_OUT;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            cste_pkg::ST_SET: begin
                o_cmd.set_wr = 1'b1;
                n_state      = cste_pkg::ST_OUT;
            end
            cste_pkg::ST_READ: begin
                o_cmd.entry_rd = 1'b1;
                n_state        = cste_pkg::ST_OUT;
            end
            cste_pkg::ST_OUT: begin
                if (!r_out_vld || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = cste_pkg::ST_IDLE;
                end
            end
            default: n_state = cste_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        if (o_cmd.out_load) begin
            n_out_vld = 1'b1;
        end else if (i_out_ready) begin
            n_out_vld = 1'b0;
        end else begin
            n_out_vld = r_out_vld;
        end
    end

    assign o_out_valid = r_out_vld;

endmodule

// ===== hw/rtl/cste_dp.sv =====
// Datapath: item capture, signal table memory, field extraction and result register.
module cste_dp #(
    parameter int NUM_ENTRIES = 16,
    parameter int AW          = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  cste_pkg::t_dp_cmd     i_cmd,
    input  logic [AW-1:0]         i_scan_addr,
    output cste_pkg::t_dp_status  o_status,
    input  logic [1:0]            i_command,
    input  logic [10:0]           i_frame_id,
    input  logic [63:0]           i_frame_data,
    input  logic [3:0]            i_entry_index,
    input  logic [10:0]           i_entry_id,
    input  logic [5:0]            i_entry_start_bit,
    input  logic [5:0]            i_entry_length,
    output logic [15:0]           o_match_mask,
    output logic [10:0]           o_read_id,
    output logic [5:0]            o_read_start_bit,
    output logic [5:0]            o_read_length,
    output logic                  o_read_enabled,
    output logic signed [31:0]    o_read_value
);

    // Field extraction: whole bytes MSB first, last byte from its in-byte offset
    function automatic logic [31:0] extract_field(logic [63:0] data, logic [5:0] start,
                                                  logic [5:0] len);
        logic [2:0]  first;
        logic [2:0]  off;
        logic [6:0]  lsum;
        logic [2:0]  nb;
        logic [3:0]  lb;
        logic [3:0]  pos;
        logic [7:0]  b [4];
        logic [23:0] w;
        logic [7:0]  last;
        logic [7:0]  lf;
        logic [31:0] res;
        first = start[5:3];
        off   = start[2:0];
        lsum  = {1'b0, len} + 7'd7;
        nb    = lsum[5:3];
        lb    = (len[2:0] == 3'd0) ? 4'd8 : {1'b0, len[2:0]};
        for (int j = 0; j < 4; j++) begin
            pos  = {1'b0, first} + 4'(j);
            b[j] = (pos < 4'd8) ? data[{pos[2:0], 3'b000} +: 8] : 8'h00;
        end
        w    = '0;
        last = '0;
        case (nb)
            3'd1: last = b[0];
            3'd2: begin
                w    = {16'h0000, b[0]};
                last = b[1];
            end
            3'd3: begin
                w    = {8'h00, b[0], b[1]};
                last = b[2];
            end
            3'd4: begin
                w    = {b[0], b[1], b[2]};
                last = b[3];
            end
            default: begin
                w    = '0;
                last = '0;
            end
        endcase
        // the last byte drops out when its bits would run past the byte
        if (({1'b0, off} + lb) <= 4'd8) begin
            lf = (last >> off) & 8'((9'h001 << lb) - 9'h001);
        end else begin
            lf = '0;
        end
        if (nb == 3'd0) begin
            res = '0;
        end else begin
            res = (32'(w) << lb) | 32'(lf);
        end
        return res;
    endfunction

    // Captured item
    logic [1:0]  r_cmd_code;
    logic [10:0] r_fid;
    logic [63:0] r_data;
    logic [3:0]  r_idx;
    logic [10:0] r_eid;
    logic [5:0]  r_estart;
    logic [5:0]  r_elen;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd_code <= i_command;
            r_fid      <= i_frame_id;
            r_data     <= i_frame_data;
            r_idx      <= i_entry_index;
            r_eid      <= i_entry_id;
            r_estart   <= i_entry_start_bit;
            r_elen     <= (i_entry_length > 6'(cste_pkg::MaxLen)) ?
                          6'(cste_pkg::MaxLen) : i_entry_length;
        end
    end

    logic [6:0]    idx_ext;
    logic [AW-1:0] idx_addr;
    logic          idx_ok;

    assign idx_ext  = 7'(r_idx);
    assign idx_addr = idx_ext[AW-1:0];
    assign idx_ok   = idx_ext < 7'(NUM_ENTRIES);

    assign o_status.cmd    = r_cmd_code;
    assign o_status.idx_ok = idx_ok;

    // Signal table memory with per-entry valid bits; an unwritten entry reads as default
    cste_pkg::t_entry r_mem [NUM_ENTRIES];
    logic [NUM_ENTRIES-1:0] r_valid;
    cste_pkg::t_entry r_rd_raw;
    logic             r_rd_vld;
    logic [AW-1:0]    r_rd_idx;

    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    logic             we;
    logic [AW-1:0]    waddr;
    cste_pkg::t_entry wdata;
    cste_pkg::t_entry eff;
    logic             match;
    logic [6:0]       proc_ext;

    assign rd_en   = i_cmd.scan_rd | i_cmd.entry_rd;
    assign rd_addr = i_cmd.scan_rd ? i_scan_addr : idx_addr;

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        if (rd_en) begin
            r_rd_raw <= r_mem[rd_addr];
            r_rd_vld <= r_valid[rd_addr];
            r_rd_idx <= rd_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (we) begin
            r_valid[waddr] <= 1'b1;
        end
    end

    assign eff      = r_rd_vld ? r_rd_raw :
                      cste_pkg::default_entry(cste_pkg::IdxMaxW'(r_rd_idx));
    assign match    = eff.enabled && (eff.id == r_fid);
    assign proc_ext = 7'(r_rd_idx);

    always_comb begin
        we    = 1'b0;
        waddr = idx_addr;
        wdata = eff;
        if (i_cmd.set_wr) begin
            we              = 1'b1;
            wdata.id        = r_eid;
            wdata.start_bit = r_estart;
            wdata.length    = r_elen;
            wdata.enabled   = 1'b1;
            wdata.value     = '1;
        end else if (i_cmd.scan_upd && match) begin
            we          = 1'b1;
            waddr       = r_rd_idx;
            wdata.value = extract_field(r_data, eff.start_bit, eff.length);
        end
    end

    // Frame match mask
    logic [15:0] r_mask;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mask <= '0;
        end else if (i_cmd.scan_upd && match && (proc_ext < 7'(cste_pkg::MaskW))) begin
            r_mask[proc_ext[3:0]] <= 1'b1;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_match_mask     <= '0;
            o_read_id        <= '0;
            o_read_start_bit <= '0;
            o_read_length    <= '0;
            o_read_enabled   <= 1'b0;
            o_read_value     <= '0;
            case (r_cmd_code)
                cste_pkg::CMD_FRAME: o_match_mask <= r_mask;
                cste_pkg::CMD_SET: begin
                    if (idx_ok) begin
                        o_read_id        <= r_eid;
                        o_read_start_bit <= r_estart;
                        o_read_length    <= r_elen;
                        o_read_enabled   <= 1'b1;
                        o_read_value     <= '1;
                    end
                end
                cste_pkg::CMD_READ: begin
                    if (idx_ok) begin
                        o_read_id        <= eff.id;
                        o_read_start_bit <= eff.start_bit;
                        o_read_length    <= eff.length;
                        o_read_enabled   <= eff.enabled;
                        o_read_value     <= eff.value;
                    end
                end
                default: o_match_mask <= '0;
            endcase
        end
    end

endmodule

// ===== hw/rtl/can_signal_table_extractor_top.sv =====
// Top level of the CAN signal table extractor: stream ports, controller and datapath.
//
//  Channel   | Dir | Signals                          | Transaction
//  ----------+-----+----------------------------------+-----------------------------------
//  s_axis    | in  | tvalid/tready, tdata[103:0],     | one command: frame, set or read
//            |     | tuser[1:0]                       |
//  m_axis    | out | tvalid/tready, tdata[71:0]       | one result per command
//
// Sequence: a command is taken in idle, decoded the next cycle, then worked on.
//   A received frame walks the table one entry a cycle through the single memory read
//   port (entry k is read while entry k-1 is matched, extracted and written back); set
//   and read pass through their own state, an unused command or an index past the
//   table goes straight to output; the next command is taken only back in idle.
// Reset: i_rst_n is synchronous, active low; it clears the controller and the valid bits
//   of the table, so every entry reads back the default signal table right away.
// Stalls: results sit in an output register, so a new command is accepted while the
//   previous result waits; the block holds in its output state only when that register
//   is still full.
module can_signal_table_extractor_top #(
    parameter int NUM_ENTRIES = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // frame_id[10:0], frame_data[74:11], entry_index[78:75], entry_id[89:79],
    // entry_start_bit[95:90], entry_length[101:96], zero pad[103:102]
    input  logic [103:0] i_s_axis_tdata,
    // command[1:0]
    input  logic [1:0]   i_s_axis_tuser,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // match_mask[15:0], read_id[26:16], read_start_bit[32:27], read_length[38:33],
    // read_enabled[39], read_value[71:40]
    output logic [71:0]  o_m_axis_tdata
);

    localparam int AW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;

    cste_pkg::t_dp_cmd    dp_cmd;
    cste_pkg::t_dp_status dp_status;
    logic [AW-1:0]        scan_addr;

    logic [15:0]        match_mask;
    logic [10:0]        read_id;
    logic [5:0]         read_start_bit;
    logic [5:0]         read_length;
    logic               read_enabled;
    logic signed [31:0] read_value;

    cste_ctrl #(
        .NUM_ENTRIES (NUM_ENTRIES),
        .AW          (AW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .i_status    (dp_status),
        .o_cmd       (dp_cmd),
        .o_scan_addr (scan_addr)
    );

    cste_dp #(
        .NUM_ENTRIES (NUM_ENTRIES),
        .AW          (AW)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (dp_cmd),
        .i_scan_addr       (scan_addr),
        .o_status          (dp_status),
        .i_command         (i_s_axis_tuser),
        .i_frame_id        (i_s_axis_tdata[10:0]),
        .i_frame_data      (i_s_axis_tdata[74:11]),
        .i_entry_index     (i_s_axis_tdata[78:75]),
        .i_entry_id        (i_s_axis_tdata[89:79]),
        .i_entry_start_bit (i_s_axis_tdata[95:90]),
        .i_entry_length    (i_s_axis_tdata[101:96]),
        .o_match_mask      (match_mask),
        .o_read_id         (read_id),
        .o_read_start_bit  (read_start_bit),
        .o_read_length     (read_length),
        .o_read_enabled    (read_enabled),
        .o_read_value      (read_value)
    );

    // Pack the result, first field in the lowest bits
    assign o_m_axis_tdata = {read_value, read_enabled, read_length, read_start_bit,
                             read_id, match_mask};

endmodule

// ===== sim/can_extract_checker.sv =====
`timescale 1ns / 1ps
// Result checker: watches both stream channels, predicts each result and compares it.
module can_extract_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cmd_tvalid,
    input  logic         i_cmd_tready,
    input  logic [103:0] i_cmd_tdata,
    input  logic [1:0]   i_cmd_tuser,
    input  logic         i_res_tvalid,
    input  logic         i_res_tready,
    input  logic [71:0]  i_res_tdata,
    output int           o_outstanding,
    output int           o_errors
);

    localparam int NumEntries = 16;

    // Same layout as the result tdata, highest field first
    typedef struct packed {
        logic [31:0] value;
        logic        enabled;
        logic [5:0]  length;
        logic [5:0]  start_bit;
        logic [10:0] id;
        logic [15:0] mask;
    } t_extract_result;

    logic [10:0] sig_id    [NumEntries];
    logic [5:0]  sig_start [NumEntries];
    logic [5:0]  sig_len   [NumEntries];
    logic        sig_en    [NumEntries];
    logic [31:0] sig_value [NumEntries];

    t_extract_result expected_q [$];
    int error_count = 0;

    assign o_errors = error_count;

    // Whole bytes MSB first; the last byte is masked through an 8-bit shift
    function automatic logic [31:0] field_value(logic [63:0] data, int start, int len);
        int first, off, nb, lb, pos;
        logic [7:0]  b, t;
        logic [31:0] acc, part;
        first = start / 8;
        off   = start % 8;
        nb    = (len + 7) / 8;
        acc   = '0;
        for (int j = 0; j < nb; j++) begin
            pos = first + j;
            b = (pos < 8) ? 8'(data >> (8 * pos)) : 8'h00;
            if (j == nb - 1) begin
                lb = len - 8 * (nb - 1);
                if (off + lb <= 8) begin
                    t = 8'(b << (8 - off - lb));
                    part = 32'(t >> (8 - lb));
                end else begin
                    // overlap past the byte edge shifts everything out
                    part = '0;
                end
            end else begin
                part = 32'(b);
            end
            if (len > 8 * (j + 1)) begin
                part = part << (len - 8 * (j + 1));
            end
            acc = acc + part;
        end
        return acc;
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0h got %0h", $time, name, want, got);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin : track
        logic [1:0]      cmd;
        logic [10:0]     fid;
        logic [63:0]     data;
        logic [3:0]      idx;
        logic [5:0]      len;
        t_extract_result want, got;
        if (!i_rst_n) begin
            for (int i = 0; i < NumEntries; i++) begin
                sig_id[i]    = cste_pkg::DfltId[i];
                sig_start[i] = cste_pkg::DfltStart[i];
                sig_len[i]   = cste_pkg::DfltLen[i];
                sig_en[i]    = (i < cste_pkg::DfltEnabled);
                sig_value[i] = '1;
            end
            expected_q.delete();
            o_outstanding <= 0;
        end else begin
            if (i_cmd_tvalid && i_cmd_tready) begin
                cmd  = i_cmd_tuser;
                fid  = i_cmd_tdata[10:0];
                data = i_cmd_tdata[74:11];
                idx  = i_cmd_tdata[78:75];
                len  = (i_cmd_tdata[101:96] > 6'd32) ? 6'd32 : i_cmd_tdata[101:96];
                want = '0;
                if (cmd == cste_pkg::CMD_FRAME) begin
                    for (int i = 0; i < NumEntries; i++) begin
                        if (sig_en[i] && sig_id[i] == fid) begin
                            sig_value[i] = field_value(data, sig_start[i], sig_len[i]);
                            want.mask[i] = 1'b1;
                        end
                    end
                end else if (cmd == cste_pkg::CMD_SET) begin
                    sig_id[idx]    = i_cmd_tdata[89:79];
                    sig_start[idx] = i_cmd_tdata[95:90];
                    sig_len[idx]   = len;
                    sig_en[idx]    = 1'b1;
                    sig_value[idx] = '1;
                end
                if (cmd == cste_pkg::CMD_SET || cmd == cste_pkg::CMD_READ) begin
                    want.id        = sig_id[idx];
                    want.start_bit = sig_start[idx];
                    want.length    = sig_len[idx];
                    want.enabled   = sig_en[idx];
                    want.value     = sig_value[idx];
                end
                expected_q.push_back(want);
            end
            if (i_res_tvalid && i_res_tready) begin
                got = i_res_tdata;
                if (expected_q.size() == 0) begin
                    $display("%0t: result expected none got %0h", $time, got);
                    error_count++;
                end else begin
                    want = expected_q.pop_front();
                    check_field("match_mask", 32'(want.mask), 32'(got.mask));
                    check_field("read_id", 32'(want.id), 32'(got.id));
                    check_field("read_start_bit", 32'(want.start_bit), 32'(got.start_bit));
                    check_field("read_length", 32'(want.length), 32'(got.length));
                    check_field("read_enabled", 32'(want.enabled), 32'(got.enabled));
                    check_field("read_value", want.value, got.value);
                end
            end
            o_outstanding <= expected_q.size();
        end
    end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench top: clock, reset, command stimulus, result backpressure and the verdict.
module tb_top;

    localparam int NumEntries  = 16;
    localparam int CycleLimit  = 500000;
    localparam int DrainCycles = 40;
    // tuser value outside the three commands
    localparam logic [1:0] CmdUnused = 2'd3;
    localparam logic [10:0] SetIdPool [4] = '{11'h360, 11'h390, 11'h3EB, 11'h7FF};

    logic         clk;
    logic         rst_n;
    logic         cmd_tvalid;
    logic         cmd_tready;
    logic [103:0] cmd_tdata;
    logic [1:0]   cmd_tuser;
    logic         res_tvalid;
    logic         res_tready;
    logic [71:0]  res_tdata;

    int outstanding;
    int errors;
    int cycles = 0;
    int src_idle_pct;
    int sink_idle_pct;

    // Identifiers currently in the table, to aim frames at live entries
    logic [10:0] id_shadow [NumEntries];

    can_signal_table_extractor_top #(
        .NUM_ENTRIES(NumEntries)
    ) dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_s_axis_tvalid(cmd_tvalid),
        .o_s_axis_tready(cmd_tready),
        .i_s_axis_tdata (cmd_tdata),
        .i_s_axis_tuser (cmd_tuser),
        .o_m_axis_tvalid(res_tvalid),
        .i_m_axis_tready(res_tready),
        .o_m_axis_tdata (res_tdata)
    );

    can_extract_checker checker_inst (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cmd_tvalid (cmd_tvalid),
        .i_cmd_tready (cmd_tready),
        .i_cmd_tdata  (cmd_tdata),
        .i_cmd_tuser  (cmd_tuser),
        .i_res_tvalid (res_tvalid),
        .i_res_tready (res_tready),
        .i_res_tdata  (res_tdata),
        .o_outstanding(outstanding),
        .o_errors     (errors)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Stall the result channel at the current rate, one decision per cycle
    always @(posedge clk) begin
        res_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // Abort a hung run
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CycleLimit) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // tdata layout: frame_id, frame_data, entry_index, entry_id, start, length, zero pad
    function automatic logic [103:0] pack_command(logic [10:0] fid, logic [63:0] data,
                                                  logic [3:0] idx, logic [10:0] eid,
                                                  logic [5:0] start, logic [5:0] len);
        return {2'b00, len, start, eid, idx, data, fid};
    endfunction

    // Offer one transaction; idle first at the sender rate, then hold until taken
    task automatic push_command(logic [1:0] cmd, logic [103:0] payload);
        while ($urandom_range(99) < src_idle_pct) begin
            cmd_tvalid <= 1'b0;
            @(posedge clk);
        end
        cmd_tvalid <= 1'b1;
        cmd_tuser  <= cmd;
        cmd_tdata  <= payload;
        do @(posedge clk); while (!cmd_tready);
    endtask

    // Fields a command ignores carry random noise
    task automatic issue_frame(logic [10:0] fid, logic [63:0] data);
        push_command(cste_pkg::CMD_FRAME, pack_command(fid, data, 4'($urandom),
                                                       11'($urandom), 6'($urandom),
                                                       6'($urandom)));
    endtask

    task automatic issue_set(logic [3:0] idx, logic [10:0] eid, logic [5:0] start,
                             logic [5:0] len);
        id_shadow[idx] = eid;
        push_command(cste_pkg::CMD_SET, pack_command(11'($urandom), {$urandom, $urandom},
                                                     idx, eid, start, len));
    endtask

    task automatic issue_read(logic [3:0] idx);
        push_command(cste_pkg::CMD_READ, pack_command(11'($urandom), {$urandom, $urandom},
                                                      idx, 11'($urandom), 6'($urandom),
                                                      6'($urandom)));
    endtask

    // Drop valid and hold until every expected result has come back
    task automatic drain;
        cmd_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
    endtask

    // Frames, most aimed at live identifiers, plus sets, reads and unused commands
    task automatic random_burst(int count);
        int          pick;
        logic [10:0] fid;
        logic [10:0] eid;
        logic [5:0]  len;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < 45) begin
                fid = ($urandom_range(9) < 7) ? id_shadow[$urandom_range(NumEntries - 1)]
                                              : 11'($urandom);
                issue_frame(fid, {$urandom, $urandom});
            end else if (pick < 65) begin
                eid = ($urandom_range(1) == 0) ? SetIdPool[$urandom_range(3)]
                                               : 11'($urandom);
                len = ($urandom_range(9) < 8) ? 6'($urandom_range(32))
                                              : 6'($urandom_range(63, 33));
                issue_set(4'($urandom), eid, 6'($urandom), len);
            end else if (pick < 92) begin
                issue_read(4'($urandom));
            end else begin
                push_command(CmdUnused, pack_command(11'($urandom), {$urandom, $urandom},
                                                     4'($urandom), 11'($urandom),
                                                     6'($urandom), 6'($urandom)));
            end
        end
    endtask

    initial begin
        for (int i = 0; i < NumEntries; i++) begin
            id_shadow[i] = cste_pkg::DfltId[i];
        end
        cmd_tvalid    <= 1'b0;
        cmd_tdata     <= '0;
        cmd_tuser     <= cste_pkg::CMD_FRAME;
        rst_n         <= 1'b0;
        src_idle_pct  = 23;
        sink_idle_pct = 72;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Default table: first, last enabled and disabled entries
        issue_read(4'd0);
        issue_read(4'd12);
        issue_read(4'd13);
        issue_read(4'd15);
        // Default frames: two entries on one id, six on another, a high start byte
        issue_frame(11'h360, 64'h0123_4567_89AB_CDEF);
        issue_frame(11'h390, '1);
        issue_frame(11'h3EB, 64'hFEDC_BA98_7654_3210);
        // Id zero only lives in disabled entries
        issue_frame(11'h000, '0);
        push_command(CmdUnused, pack_command('1, '1, '1, '1, '1, '1));
        // Saturated length at the top start bit: overlap and bytes past the frame
        issue_set(4'd15, 11'h7FF, 6'd63, 6'd63);
        issue_frame(11'h7FF, '1);
        issue_read(4'd15);
        // Zero length stores zero
        issue_set(4'd14, 11'h000, 6'd0, 6'd0);
        issue_frame(11'h000, '1);
        issue_read(4'd14);
        // Short field that ends exactly at the byte edge
        issue_set(4'd13, 11'h123, 6'd5, 6'd3);
        issue_frame(11'h123, 64'hA5A5_5A5A_F00F_0FF0);
        issue_read(4'd13);
        // Last byte runs past the byte edge
        issue_set(4'd0, 11'h360, 6'd61, 6'd12);
        issue_frame(11'h360, '1);
        issue_read(4'd0);
        // Full 32 bits starting in the last byte
        issue_set(4'd1, 11'h360, 6'd56, 6'd32);
        issue_frame(11'h360, 64'h8877_6655_4433_2211);
        issue_read(4'd1);
        issue_read(4'd3);

        random_burst(240);
        drain;

        src_idle_pct  = 72;
        sink_idle_pct = 23;
        random_burst(240);
        drain;

        src_idle_pct  = 0;
        sink_idle_pct = 0;
        random_burst(220);
        drain;

        // Catch any stray result after the last one
        repeat (DrainCycles) @(posedge clk);
        if (errors == 0 && outstanding == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
